// ===== rtl/pcbe_pkg.sv =====
// Shared types and constants of the piecewise cubic Bezier evaluator.
`default_nettype none

package pcbe_pkg;

	localparam int TABLE_AW  = 6;
	localparam int PT_W      = 16;
	localparam int T_W       = 17;
	localparam int CFG_W     = 5;
	localparam int DIV_STEPS = 17;

	localparam logic [T_W-1:0] T_ONE = 17'd65536;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic CFG_KNOTS_ONLY = 1'b0;
	localparam logic CFG_SPAN_TOTAL = 1'b1;

	// Horner step that adds the last coefficient.
	localparam logic [1:0] STEP_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_MUL_TGT,
		ST_RD_P0,
		ST_RD_P3,
		ST_CMP,
		ST_RD_P1,
		ST_RD_P2,
		ST_DIV_INIT,
		ST_DIV,
		ST_H_MA,
		ST_H_ADD,
		ST_H_MHI,
		ST_H_MLO,
		ST_H_FIN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		SLOT_P0,
		SLOT_P1,
		SLOT_P2,
		SLOT_P3,
		SLOT_LAST
	} slot_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_TGT,
		MUL_A,
		MUL_HI,
		MUL_LO
	} mul_sel_t;

	typedef enum logic [1:0] {
		ADD_NONE,
		ADD_B,
		ADD_C,
		ADD_D
	} add_sel_t;

	typedef struct packed {
		logic                wr_en;
		logic                start;
		logic                rd_en;
		logic [TABLE_AW-1:0] rd_addr;
		slot_t               rd_slot;
		mul_sel_t            mul_sel;
		add_sel_t            add_sel;
		logic                div_init;
		logic                div_step;
		logic                fin;
		logic                coord;
		logic                load_out;
		logic                out_found;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic div_zero;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/piecewise_cubic_bezier_eval_unit.sv =====
// Piecewise cubic Bezier evaluator: top level with configuration registers.
//
// Input channel (in_valid/in_ready): a write beat (opcode 0) stores point_x_in and
// point_y_in in table slot point_index. An evaluate beat (opcode 1) scales the x
// of the last knot by t_global, searches the spans in order for the first one whose
// x range holds it, divides for local t and runs Horner's rule for x and then y on
// a single shared multiplier.
// Output channel (out_valid/out_ready): one beat per evaluate, x_pos, y_pos, found;
// a miss gives found 0 with zero coordinates.
// An evaluate beat runs the span search, the restoring divider (skipped for a
// zero-width span) and the eighteen Horner steps; one item is in work at a time.
// The result sits in an output register, so the next beat is accepted while it
// waits; a finished result stalls only if the previous one is still held.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle; the
// block does not enforce this. Reset clears the control state, sets knots_only to 0
// and span_total to 1; table contents are undefined until written.
`default_nettype none

module piecewise_cubic_bezier_eval_unit import pcbe_pkg::*; #(
	parameter int MAX_SPANS  = 16,
	parameter int COORD_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    opcode,
	input  wire logic [TABLE_AW-1:0]     point_index,
	input  wire logic signed [PT_W-1:0]  point_x_in,
	input  wire logic signed [PT_W-1:0]  point_y_in,
	input  wire logic [T_W-1:0]          t_global,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [COORD_BITS-1:0] x_pos,
	output logic signed [COORD_BITS-1:0] y_pos,
	output logic                         found,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data
);

	logic             knots_only_q;
	logic [CFG_W-1:0] span_total_q;
	cmd_t             cmd;
	status_t          status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knots_only_q <= 1'b0;
			span_total_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KNOTS_ONLY: knots_only_q <= cfg_data[0];
				CFG_SPAN_TOTAL: span_total_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	pcbe_ctrl #(
		.MAX_SPANS(MAX_SPANS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.knots_only (knots_only_q),
		.span_total (span_total_q),
		.status     (status),
		.cmd        (cmd)
	);

	pcbe_datapath #(
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk         (clk),
		.point_index (point_index),
		.point_x_in  (point_x_in),
		.point_y_in  (point_y_in),
		.t_global    (t_global),
		.cmd         (cmd),
		.status      (status),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.found       (found)
	);

	// A miss always reports the origin.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> x_pos == '0 && y_pos == '0)
		else $error("miss result carries nonzero coordinates");

	// An evaluate beat occupies the block, so it cannot take a beat the next cycle.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_EVAL |=> !in_ready)
		else $error("input accepted right after an evaluate beat");

	// A new result is only produced while the block is busy with an evaluate.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

endmodule

`default_nettype wire

// ===== rtl/pcbe_datapath.sv =====
// Datapath: point tables, span test, local-t divider, shared multiplier and Horner unit.
`default_nettype none

module pcbe_datapath import pcbe_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic [TABLE_AW-1:0]          point_index,
	input  wire logic signed [PT_W-1:0]       point_x_in,
	input  wire logic signed [PT_W-1:0]       point_y_in,
	input  wire logic [T_W-1:0]               t_global,
	input  wire cmd_t                         cmd,
	output status_t                           status,
	output logic signed [COORD_BITS-1:0]      x_pos,
	output logic signed [COORD_BITS-1:0]      y_pos,
	output logic                              found
);

	localparam logic signed [39:0] SAT_MAX = (40'sd1 <<< (COORD_BITS - 1)) - 40'sd1;
	localparam logic signed [39:0] SAT_MIN = -SAT_MAX - 40'sd1;

	logic signed [PT_W-1:0] mem_x_q [2**TABLE_AW];
	logic signed [PT_W-1:0] mem_y_q [2**TABLE_AW];

	logic signed [PT_W-1:0] px_q [4];
	logic signed [PT_W-1:0] py_q [4];
	logic signed [PT_W-1:0] lastx_q;
	logic [T_W-1:0]         t_q;
	logic signed [33:0]     target_q;
	logic signed [39:0]     prod_q;
	logic [32:0]            lo_q;
	logic signed [39:0]     h_q;
	logic [16:0]            rem_q;
	logic [16:0]            numlo_q;
	logic [16:0]            dvs_q;
	logic [T_W-1:0]         q_q;
	logic signed [COORD_BITS-1:0] xres_q;
	logic signed [COORD_BITS-1:0] yres_q;
	logic signed [COORD_BITS-1:0] x_pos_q;
	logic signed [COORD_BITS-1:0] y_pos_q;
	logic                         found_q;

	logic signed [33:0] lo_sh;
	logic signed [33:0] hi_sh;
	logic signed [33:0] num;
	logic [16:0]        dvs;
	logic [17:0]        trial;
	logic               ge;

	logic signed [19:0] e0, e1, e2, e3;
	logic signed [19:0] coef_a, coef_b, coef_c, coef_d, coef_sel;

	logic signed [23:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [41:0] mul_p;

	logic [33:0]        lo_rnd;
	logic signed [39:0] rnd_ext;
	logic signed [39:0] coef_sh;
	logic signed [39:0] h_next;
	logic signed [39:0] h_rnd;
	logic signed [39:0] v;
	logic signed [39:0] sat_v;

	// Table writes and reads; each read lands directly in its operand register.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_x_q[point_index] <= point_x_in;
			mem_y_q[point_index] <= point_y_in;
		end
		if (cmd.rd_en) begin
			if (cmd.rd_slot == SLOT_LAST) begin
				lastx_q <= mem_x_q[cmd.rd_addr];
			end else begin
				px_q[cmd.rd_slot[1:0]] <= mem_x_q[cmd.rd_addr];
				py_q[cmd.rd_slot[1:0]] <= mem_y_q[cmd.rd_addr];
			end
		end
	end

	// Span test against the target x, which carries 16 fraction bits.
	assign lo_sh = 34'(px_q[0]) <<< 16;
	assign hi_sh = 34'(px_q[3]) <<< 16;
	assign num   = target_q - lo_sh;
	assign dvs   = 17'(px_q[3]) - 17'(px_q[0]);

	assign status.hit      = (target_q >= lo_sh) && (target_q <= hi_sh);
	assign status.div_zero = (px_q[3] == px_q[0]);

	// Restoring divider, one quotient bit per cycle.
	assign trial = {rem_q, numlo_q[16]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			t_q <= (t_global > T_ONE) ? T_ONE : t_global;
		end
		if (cmd.div_init) begin
			rem_q   <= num[33:17];
			numlo_q <= num[16:0];
			dvs_q   <= dvs;
			q_q     <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= ge ? 17'(trial - {1'b0, dvs_q}) : trial[16:0];
			numlo_q <= {numlo_q[15:0], 1'b0};
			q_q     <= {q_q[15:0], ge};
		end
	end

	// Cubic coefficients of the selected coordinate.
	always_comb begin
		if (cmd.coord) begin
			e0 = 20'(py_q[0]);
			e1 = 20'(py_q[1]);
			e2 = 20'(py_q[2]);
			e3 = 20'(py_q[3]);
		end else begin
			e0 = 20'(px_q[0]);
			e1 = 20'(px_q[1]);
			e2 = 20'(px_q[2]);
			e3 = 20'(px_q[3]);
		end
		coef_a = e3 - e0 + 20'sd3 * (e1 - e2);
		coef_b = 20'sd3 * (e0 + e2) - 20'sd6 * e1;
		coef_c = 20'sd3 * (e1 - e0);
		coef_d = e0;
	end

	// The one multiplier, shared by the target scale and all Horner products.
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_TGT: begin
				mul_a = 24'(lastx_q);
				mul_b = {1'b0, t_q};
			end
			MUL_A: begin
				mul_a = 24'(coef_a);
				mul_b = {1'b0, q_q};
			end
			MUL_HI: begin
				mul_a = h_q[39:16];
				mul_b = {1'b0, q_q};
			end
			MUL_LO: begin
				mul_a = {8'd0, h_q[15:0]};
				mul_b = {1'b0, q_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.mul_sel)
			MUL_TGT:       target_q <= mul_p[33:0];
			MUL_A, MUL_HI: prod_q   <= mul_p[39:0];
			MUL_LO:        lo_q     <= mul_p[32:0];
			default:       ;
		endcase
	end

	// Horner accumulate: high product plus rounded low product plus coefficient; the B step adds no low product.
	always_comb begin
		unique case (cmd.add_sel)
			ADD_B:   coef_sel = coef_b;
			ADD_C:   coef_sel = coef_c;
			default: coef_sel = coef_d;
		endcase
		lo_rnd  = 34'(lo_q) + 34'd32768;
		rnd_ext = (cmd.add_sel == ADD_B) ? 40'sd0 : $signed({22'd0, lo_rnd[33:16]});
		coef_sh = 40'(coef_sel) <<< 16;
		h_next  = prod_q + coef_sh + rnd_ext;
	end

	always_comb begin
		h_rnd = h_q + 40'sd32768;
		v     = h_rnd >>> 16;
		if (v > SAT_MAX) begin
			sat_v = SAT_MAX;
		end else if (v < SAT_MIN) begin
			sat_v = SAT_MIN;
		end else begin
			sat_v = v;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_sel != ADD_NONE) begin
			h_q <= h_next;
		end
		if (cmd.fin) begin
			if (cmd.coord) begin
				yres_q <= sat_v[COORD_BITS-1:0];
			end else begin
				xres_q <= sat_v[COORD_BITS-1:0];
			end
		end
		if (cmd.load_out) begin
			x_pos_q <= cmd.out_found ? xres_q : '0;
			y_pos_q <= cmd.out_found ? yres_q : '0;
			found_q <= cmd.out_found;
		end
	end

	assign x_pos = x_pos_q;
	assign y_pos = y_pos_q;
	assign found = found_q;

endmodule

`default_nettype wire

// ===== rtl/pcbe_ctrl.sv =====
// Controller: sequences the span search, division and Horner steps of one beat.
`default_nettype none

module pcbe_ctrl import pcbe_pkg::*; #(
	parameter int MAX_SPANS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             opcode,
	input  wire logic             out_ready,
	output logic                  out_valid,
	input  wire logic             knots_only,
	input  wire logic [CFG_W-1:0] span_total,
	input  wire status_t          status,
	output cmd_t                  cmd
);

	localparam int SPAN_W = $clog2(MAX_SPANS + 1);

	state_t              state_q, state_d;
	logic [SPAN_W-1:0]   n_q;
	logic [SPAN_W-1:0]   span_q;
	logic [4:0]          cnt_q;
	logic [1:0]          step_q;
	logic                coord_q;
	logic                found_q;
	logic                out_valid_q;

	logic [SPAN_W-1:0]   n_eff;
	logic [TABLE_AW-1:0] base;
	logic [TABLE_AW-1:0] last_addr;
	logic                last_span;

	always_comb begin
		if (span_total == '0) begin
			n_eff = SPAN_W'(1);
		end else if (32'(span_total) > MAX_SPANS) begin
			n_eff = SPAN_W'(MAX_SPANS);
		end else begin
			n_eff = SPAN_W'(span_total);
		end
	end

	// Slot addresses wrap around the 64-entry table.
	assign base      = knots_only ? TABLE_AW'(span_q) : TABLE_AW'(3 * span_q);
	assign last_addr = knots_only ? TABLE_AW'(n_q) : TABLE_AW'(3 * n_q);
	assign last_span = (span_q == SPAN_W'(n_q - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.coord     = coord_q;
		cmd.out_found = found_q;
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_RD_LAST;
					end
				end
			end
			ST_RD_LAST: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = last_addr;
				cmd.rd_slot = SLOT_LAST;
				state_d     = ST_MUL_TGT;
			end
			ST_MUL_TGT: begin
				cmd.mul_sel = MUL_TGT;
				state_d     = ST_RD_P0;
			end
			ST_RD_P0: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = base;
				cmd.rd_slot = SLOT_P0;
				state_d     = ST_RD_P3;
			end
			ST_RD_P3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = knots_only ? base + 6'd1 : base + 6'd3;
				cmd.rd_slot = SLOT_P3;
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				if (status.hit) begin
					state_d = ST_RD_P1;
				end else if (last_span) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RD_P0;
				end
			end
			ST_RD_P1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = knots_only ? base : base + 6'd1;
				cmd.rd_slot = SLOT_P1;
				state_d     = ST_RD_P2;
			end
			ST_RD_P2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = knots_only ? base + 6'd1 : base + 6'd2;
				cmd.rd_slot = SLOT_P2;
				state_d     = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = status.div_zero ? ST_H_MA : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = ST_H_MA;
				end
			end
			ST_H_MA: begin
				cmd.mul_sel = MUL_A;
				state_d     = ST_H_ADD;
			end
			ST_H_ADD: begin
				unique case (step_q)
					2'd0:    cmd.add_sel = ADD_B;
					2'd1:    cmd.add_sel = ADD_C;
					default: cmd.add_sel = ADD_D;
				endcase
				state_d = (step_q == STEP_LAST) ? ST_H_FIN : ST_H_MHI;
			end
			ST_H_MHI: begin
				cmd.mul_sel = MUL_HI;
				state_d     = ST_H_MLO;
			end
			ST_H_MLO: begin
				cmd.mul_sel = MUL_LO;
				state_d     = ST_H_ADD;
			end
			ST_H_FIN: begin
				cmd.fin = 1'b1;
				state_d = coord_q ? ST_DONE : ST_H_MA;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= SPAN_W'(1);
			span_q      <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			coord_q     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				n_q     <= n_eff;
				span_q  <= '0;
				found_q <= 1'b0;
			end
			if (state_q == ST_CMP && !status.hit && !last_span) begin
				span_q <= span_q + 1'b1;
			end
			if (state_q == ST_DIV_INIT) begin
				cnt_q   <= '0;
				coord_q <= 1'b0;
				step_q  <= '0;
				found_q <= 1'b1;
			end
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_H_ADD && step_q != STEP_LAST) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == ST_H_FIN) begin
				coord_q <= 1'b1;
				step_q  <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sim/piecewise_cubic_bezier_eval_unit_tb.sv =====
// Testbench for the piecewise cubic Bezier evaluator: directed and random traffic checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none

module piecewise_cubic_bezier_eval_unit_tb;
	import pcbe_pkg::*;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               found;
	} curve_point_t;

	class curve_point_checker;
		logic signed [15:0] tab_x[64];
		logic signed [15:0] tab_y[64];
		logic               knots_only;
		logic [4:0]         span_total;
		curve_point_t       pending_points[$];
		int unsigned        mismatches;
		int unsigned        checked;
		int unsigned        hits;

		function new();
			foreach (tab_x[i]) begin
				tab_x[i] = '0;
				tab_y[i] = '0;
			end
			knots_only = 1'b0;
			span_total = 5'd1;
			mismatches = 0;
			checked = 0;
			hits = 0;
		endfunction

		function void set_reg(logic idx, logic [4:0] data);
			if (idx == CFG_KNOTS_ONLY)
				knots_only = data[0];
			else
				span_total = data;
		endfunction

		// Product by t rescaled to Q16, rounding half toward +inf.
		function longint mul_t(longint h, longint t);
			longint hi;
			longint lo;
			hi = h >>> 16;
			lo = h - hi * 65536;
			return hi * t + ((lo * t + 32768) >>> 16);
		endfunction

		function longint bezier_coord(longint p0, longint p1, longint p2, longint p3, longint t);
			longint a;
			longint b;
			longint c;
			longint h;
			a = -p0 + 3 * p1 - 3 * p2 + p3;
			b = 3 * p0 - 6 * p1 + 3 * p2;
			c = -3 * p0 + 3 * p1;
			h = a * t + b * 65536;
			h = mul_t(h, t) + c * 65536;
			h = mul_t(h, t) + p0 * 65536;
			h = (h + 32768) >>> 16;
			if (h > 32767)
				h = 32767;
			if (h < -32768)
				h = -32768;
			return h;
		endfunction

		function void note_beat(logic op, logic [5:0] idx, logic signed [15:0] px,
				logic signed [15:0] py, logic [16:0] tg);
			curve_point_t e;
			int unsigned  n;
			int unsigned  s[4];
			longint       t;
			longint       tgt;
			longint       x[4];
			longint       y[4];
			longint       lt;
			if (op == OP_WRITE) begin
				tab_x[idx] = px;
				tab_y[idx] = py;
				return;
			end
			n = (span_total == 0) ? 1 : (span_total > 16) ? 16 : span_total;
			t = (tg > T_ONE) ? 65536 : tg;
			tgt = t * tab_x[(knots_only ? n : 3 * n) % 64];
			e.x = '0;
			e.y = '0;
			e.found = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (knots_only) begin
					s[0] = i; s[1] = i; s[2] = i + 1; s[3] = i + 1;
				end else begin
					s[0] = 3 * i; s[1] = 3 * i + 1; s[2] = 3 * i + 2; s[3] = 3 * i + 3;
				end
				for (int k = 0; k < 4; k++) begin
					x[k] = tab_x[s[k]];
					y[k] = tab_y[s[k]];
				end
				if (tgt < x[0] * 65536 || tgt > x[3] * 65536)
					continue;
				lt = (x[3] == x[0]) ? 0 : (tgt - x[0] * 65536) / (x[3] - x[0]);
				e.x = 16'(bezier_coord(x[0], x[1], x[2], x[3], lt));
				e.y = 16'(bezier_coord(y[0], y[1], y[2], y[3], lt));
				e.found = 1'b1;
				break;
			end
			pending_points.push_back(e);
		endfunction

		function void check_beat(logic signed [15:0] ax, logic signed [15:0] ay, logic af);
			curve_point_t e;
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result x=%0d y=%0d found=%0b", $realtime, ax, ay, af);
				return;
			end
			e = pending_points.pop_front();
			checked++;
			if (af)
				hits++;
			if (ax !== e.x || ay !== e.y || af !== e.found) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch expected x=%0d y=%0d found=%0b, got x=%0d y=%0d found=%0b",
						$realtime, e.x, e.y, e.found, ax, ay, af);
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    opcode;
	logic [TABLE_AW-1:0]     point_index;
	logic signed [PT_W-1:0]  point_x_in;
	logic signed [PT_W-1:0]  point_y_in;
	logic [T_W-1:0]          t_global;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [15:0]      x_pos;
	logic signed [15:0]      y_pos;
	logic                    found;
	logic                    cfg_we;
	logic                    cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	curve_point_checker sb;
	logic               hold_req;
	logic               no_gaps;
	int unsigned        items_sent;
	int unsigned        idle_cycles;
	logic               written[64];

	piecewise_cubic_bezier_eval_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .point_index(point_index),
		.point_x_in(point_x_in), .point_y_in(point_y_in), .t_global(t_global),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_pos(x_pos), .y_pos(y_pos), .found(found),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one beat and returns once it has been accepted.
	task automatic send_beat(logic op, logic [5:0] idx, logic signed [15:0] px,
			logic signed [15:0] py, logic [16:0] tg);
		int unsigned gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		point_index <= idx;
		point_x_in <= px;
		point_y_in <= py;
		t_global <= tg;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(op, idx, px, py, tg);
		if (op == OP_WRITE)
			written[idx] = 1'b1;
		items_sent++;
	endtask

	task automatic write_point(int unsigned idx, int px, int py);
		send_beat(OP_WRITE, idx[5:0], px[15:0], py[15:0], 17'($urandom_range(0, 131071)));
	endtask

	task automatic eval_at(int unsigned tg);
		send_beat(OP_EVAL, 6'($urandom_range(0, 63)), 16'($urandom), 16'($urandom), tg[16:0]);
	endtask

	task automatic write_reg(logic idx, logic [4:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	// Lets the block drain before its registers change.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_points.size() != 0)
			@(posedge clk);
		repeat (120) @(negedge clk);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			default: return $signed($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int pick_t();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(65537, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	// Fills every slot the current setting reads; shape 0 puts the knots in non-decreasing x,
	// shape 1 is random, shape 2 puts all knots at one x.
	task automatic fill_spans(int unsigned n, logic kn, int unsigned shape);
		int unsigned slots;
		int          step;
		int          base;
		int          kx;
		slots = kn ? n + 1 : 3 * n + 1;
		step = $urandom_range(0, 65535 / n);
		base = $urandom_range(0, 65535 - step * n) - 32768;
		for (int j = 0; j < slots; j++) begin
			kx = base + (kn ? j : j / 3) * step;
			if (shape == 1 || (!kn && j % 3 != 0 && $urandom_range(0, 1)))
				kx = rand_coord();
			else if (shape == 2)
				kx = base;
			write_point(j, kx, rand_coord());
		end
	endtask

	initial begin
		int unsigned hold_cnt;
		int unsigned stall;
		hold_cnt = 0;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_cnt = 400;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				out_ready <= 1'b0;
				hold_cnt--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_beat(x_pos, y_pos, found);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 5000) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		int unsigned nsl;
		int unsigned len;
		int unsigned phase;
		logic        kn;
		logic [4:0]  st;
		logic        ok;
		sb = new();
		hold_req = 1'b0;
		no_gaps = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		foreach (written[i])
			written[i] = 1'b0;
		in_valid = 1'b0;
		opcode = OP_WRITE;
		point_index = '0;
		point_x_in = '0;
		point_y_in = '0;
		t_global = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_KNOTS_ONLY;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: one span at its reset setting, extreme coordinates and t.
		write_point(0, 0, -32768);
		write_point(1, -32768, 32767);
		write_point(2, 32767, 32767);
		write_point(3, 1000, -32768);
		eval_at(0);
		eval_at(1);
		eval_at(32768);
		eval_at(65536);
		eval_at(131071);
		write_point(1, 32767, -32768);
		write_point(2, -32768, 32767);
		eval_at(49152);
		// Zero-width span, then a target outside the span.
		write_point(0, 1000, 5);
		eval_at(65536);
		eval_at(0);
		write_point(0, 2000, 5);
		eval_at(65536);
		eval_at(0);

		phase = 0;
		while (items_sent < 1700) begin
			drain();
			case (phase)
				0: begin kn = 1'b0; st = 5'd16; end
				1: begin kn = 1'b1; st = 5'd16; end
				2: begin kn = 1'b1; st = 5'd1; end
				3: begin kn = 1'b0; st = 5'd0; end
				4: begin kn = 1'b1; st = 5'd31; end
				default: begin
					kn = $urandom_range(0, 1);
					st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
						: $urandom_range(1, 5);
				end
			endcase
			write_reg(CFG_KNOTS_ONLY, {4'd0, kn});
			write_reg(CFG_SPAN_TOTAL, st);
			n = (st == 0) ? 1 : (st > 16) ? 16 : st;
			nsl = kn ? n + 1 : 3 * n + 1;
			no_gaps = ($urandom_range(0, 4) == 0);
			fill_spans(n, kn, ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
			if (phase == 2)
				hold_req = 1'b1;
			len = $urandom_range(20, 60);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) < 2) begin
					write_point($urandom_range(0, 63), rand_coord(), rand_coord());
				end else begin
					ok = 1'b1;
					for (int j = 0; j < nsl; j++)
						ok &= written[j];
					if (ok)
						eval_at(pick_t());
				end
			end
			phase++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_points.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		$display("Sent %0d beats over %0d settings; %0d results checked, %0d inside a span.",
			items_sent, phase, sb.checked, sb.hits);
		if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
